// ===== rtl/ssof_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the scan sector obstacle flag block.
package ssof_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int DEF_MAX_POINTS = 4096;
    localparam int DEF_RANGE_BITS = 16;

    // Configuration register widths and reset values
    localparam int LIMIT_W   = 16;
    localparam int CUT_W     = 16;
    localparam int STEP_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [LIMIT_W-1:0] RESET_NEAR_LIMIT = LIMIT_W'(500);
    localparam logic [CUT_W-1:0]   RESET_CUT_ANGLE  = CUT_W'(0);
    localparam logic [STEP_W-1:0]  RESET_ANGLE_STEP = STEP_W'(256);

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR_LIMIT = 2'd0,
        REG_CUT_ANGLE  = 2'd1,
        REG_ANGLE_STEP = 2'd2
    } cfg_reg_t;

    // Angles in 1/256 degree: a full turn is 92160
    localparam int SECTOR_COUNT = 5;
    localparam int BOUND_W      = 17;
    localparam int SECTOR_W_W   = 15;
    localparam logic [BOUND_W-1:0] FULL_TURN = BOUND_W'(92160);
    localparam int RESET_SECTOR_W = 92160 / SECTOR_COUNT;

    // Divide by five: (x * 104858) >> 19 is exact for x below 2^18
    localparam logic [BOUND_W-1:0] DIV5_MUL   = BOUND_W'(104858);
    localparam int                 DIV5_SHIFT = 19;

    // Output word: five flags from bit 0 (right) to bit 4 (left), padded to a byte
    localparam int OUT_W = 8;

    // Sector boundaries: entry 0 is the cut angle, entry k the top of sector k-1
    typedef logic [SECTOR_COUNT:0][BOUND_W-1:0] bound_vec_t;

    // Control bits that travel with a sample down the pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic near;
    } stage_ctrl_t;

endpackage

// ===== rtl/ssof_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers and the derived sector boundary table.
module ssof_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [ssof_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssof_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [ssof_pkg::LIMIT_W-1:0]      near_limit,
    output logic [ssof_pkg::STEP_W-1:0]       angle_step,
    output ssof_pkg::bound_vec_t              bounds
);
    import ssof_pkg::*;

    logic [LIMIT_W-1:0]      near_limit_reg;
    logic [CUT_W-1:0]        cut_angle_reg;
    logic [STEP_W-1:0]       angle_step_reg;
    logic [SECTOR_W_W-1:0]   sector_w_reg;
    logic [SECTOR_W_W-1:0]   sector_w_next;
    bound_vec_t              bounds_reg;
    bound_vec_t              bounds_next;
    logic [BOUND_W-1:0]      twice_cut;
    logic [BOUND_W-1:0]      span;
    logic [2*BOUND_W-1:0]    span_scaled;

    always_comb begin
        twice_cut   = {cut_angle_reg, 1'b0};
        span        = FULL_TURN - twice_cut;
        span_scaled = (2*BOUND_W)'(span) * (2*BOUND_W)'(DIV5_MUL);
        // Oversized cut zone leaves every sector empty
        if (twice_cut >= FULL_TURN) begin
            sector_w_next = '0;
        end else begin
            sector_w_next = span_scaled[DIV5_SHIFT +: SECTOR_W_W];
        end
    end

    always_comb begin
        for (int k = 0; k <= SECTOR_COUNT; k++) begin
            bounds_next[k] = BOUND_W'(cut_angle_reg)
                           + BOUND_W'(sector_w_reg) * BOUND_W'(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_limit_reg <= RESET_NEAR_LIMIT;
            cut_angle_reg  <= RESET_CUT_ANGLE;
            angle_step_reg <= RESET_ANGLE_STEP;
            sector_w_reg   <= SECTOR_W_W'(RESET_SECTOR_W);
            for (int k = 0; k <= SECTOR_COUNT; k++) begin
                bounds_reg[k] <= BOUND_W'(RESET_SECTOR_W * k);
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_NEAR_LIMIT: near_limit_reg <= cfg_data[LIMIT_W-1:0];
                    REG_CUT_ANGLE:  cut_angle_reg  <= cfg_data[CUT_W-1:0];
                    REG_ANGLE_STEP: angle_step_reg <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            sector_w_reg <= sector_w_next;
            bounds_reg   <= bounds_next;
        end
    end

    assign near_limit = near_limit_reg;
    assign angle_step = angle_step_reg;
    assign bounds     = bounds_reg;

endmodule

// ===== rtl/ssof_front.sv =====
`timescale 1ns / 1ps
// Input register, point counter, near test and angle multiply stage.
module ssof_front #(
    parameter int MAX_POINTS = ssof_pkg::DEF_MAX_POINTS,
    parameter int RANGE_BITS = ssof_pkg::DEF_RANGE_BITS,
    localparam int IDX_W = $clog2(MAX_POINTS),
    localparam int ANG_W = IDX_W + ssof_pkg::STEP_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [RANGE_BITS-1:0]         in_range,
    input  logic                          in_last,
    input  logic [ssof_pkg::LIMIT_W-1:0]  near_limit,
    input  logic [ssof_pkg::STEP_W-1:0]   angle_step,
    output ssof_pkg::stage_ctrl_t         s2_ctrl,
    output logic [ANG_W-1:0]              s2_angle,
    input  logic                          s2_ready
);
    import ssof_pkg::*;

    localparam int CMP_W = (RANGE_BITS > LIMIT_W) ? RANGE_BITS : LIMIT_W;

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    stage_ctrl_t       s1_ctrl_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    stage_ctrl_t       s2_ctrl_reg;
    logic [ANG_W-1:0]  s2_angle_reg;
    logic              accept;
    logic              s2_take;
    logic              is_near;

    assign s2_take  = !s2_ctrl_reg.valid || s2_ready;
    assign in_ready = !s1_ctrl_reg.valid || s2_take;
    assign accept   = in_valid && in_ready;

    // First point of a scan is never tested
    assign is_near = (idx_reg != '0) && (in_range != '0)
                   && (CMP_W'(in_range) < CMP_W'(near_limit));

    always_comb begin
        if (in_last || idx_reg == IDX_W'(MAX_POINTS - 1)) begin
            idx_next = '0;
        end else begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg           <= '0;
            s1_ctrl_reg.valid <= 1'b0;
            s2_ctrl_reg.valid <= 1'b0;
        end else begin
            if (accept) begin
                idx_reg          <= idx_next;
                s1_ctrl_reg.last <= in_last;
                s1_ctrl_reg.near <= is_near;
                s1_idx_reg       <= idx_reg;
            end
            if (in_ready) begin
                s1_ctrl_reg.valid <= accept;
            end
            if (s2_take) begin
                s2_ctrl_reg.valid <= s1_ctrl_reg.valid;
            end
            if (s2_take && s1_ctrl_reg.valid) begin
                s2_ctrl_reg.last <= s1_ctrl_reg.last;
                s2_ctrl_reg.near <= s1_ctrl_reg.near;
                s2_angle_reg     <= ANG_W'(s1_idx_reg) * ANG_W'(angle_step);
            end
        end
    end

    assign s2_ctrl  = s2_ctrl_reg;
    assign s2_angle = s2_angle_reg;

endmodule

// ===== rtl/ssof_accum.sv =====
`timescale 1ns / 1ps
// Sector test, flag accumulation and the output register.
module ssof_accum #(
    parameter int MAX_POINTS = ssof_pkg::DEF_MAX_POINTS,
    localparam int ANG_W = $clog2(MAX_POINTS) + ssof_pkg::STEP_W
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ssof_pkg::stage_ctrl_t        s2_ctrl,
    input  logic [ANG_W-1:0]             s2_angle,
    output logic                         s2_ready,
    input  ssof_pkg::bound_vec_t         bounds,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ssof_pkg::OUT_W-1:0]   out_data
);
    import ssof_pkg::*;

    logic [SECTOR_COUNT-1:0] flags_reg;
    logic [SECTOR_COUNT-1:0] hit;
    logic                    out_valid_reg;
    logic [SECTOR_COUNT-1:0] out_flags_reg;
    logic                    out_free;
    logic                    flush;

    always_comb begin
        for (int k = 0; k < SECTOR_COUNT; k++) begin
            hit[k] = (ANG_W'(bounds[k]) < s2_angle)
                  && (s2_angle <= ANG_W'(bounds[k+1]));
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    // Hold a last sample until the output register can take its word
    assign s2_ready = !s2_ctrl.last || out_free;
    assign flush    = s2_ctrl.valid && s2_ctrl.last && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (flush) begin
                flags_reg <= '0;
            end else if (s2_ctrl.valid && !s2_ctrl.last && s2_ctrl.near) begin
                flags_reg <= flags_reg | hit;
            end
            if (flush) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (flush) begin
            out_flags_reg <= flags_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_W'(out_flags_reg);

endmodule

// ===== rtl/scan_sector_obstacle_flags.sv =====
`timescale 1ns / 1ps
// Top level of the scan sector obstacle flag block.
//
// One range sample per input word on s_axis; s_axis_tlast marks the last point
// of a scan. The first and last points of a scan are never tested. A sample is
// near when it is nonzero and below near_limit; its angle is point index times
// angle_step in 1/256 degree. The span outside the body cut zone is split into
// five sectors, right to left, and each sector flag collects near points.
// On the last point one word leaves on m_axis with the five flags, and the
// flags and point counter clear. Other points produce no output word.
// Throughput is one word per cycle unless m_axis stalls, as below. The result
// word passes the input register, the angle multiply stage and the sector test
// into the output register; the index by step multiply sets the clock. The
// user writes cfg_* registers only while the block is idle; the block does not
// enforce it. Bounds follow a cut_angle write via sector_w_reg, bounds_reg.
// Reset clears the counter, flags and pipeline and loads register defaults.
// When m_axis stalls the result word holds and samples keep flowing until a
// second last point reaches the output stage, which then stalls s_axis.
module scan_sector_obstacle_flags #(
    parameter int MAX_POINTS = ssof_pkg::DEF_MAX_POINTS,
    parameter int RANGE_BITS = ssof_pkg::DEF_RANGE_BITS,
    localparam int IN_W = ((RANGE_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_W-1:0]                   s_axis_tdata,  // range_mm
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // obstacle_right, obstacle_front_right, obstacle_front,
    // obstacle_front_left, obstacle_left, zero padding
    output logic [ssof_pkg::OUT_W-1:0]        m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssof_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssof_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ssof_pkg::*;

    localparam int ANG_W = $clog2(MAX_POINTS) + STEP_W;

    logic [LIMIT_W-1:0] near_limit;
    logic [STEP_W-1:0]  angle_step;
    bound_vec_t         bounds;
    stage_ctrl_t        s2_ctrl;
    logic [ANG_W-1:0]   s2_angle;
    logic               s2_ready;

    assign cfg_ready = 1'b1;

    ssof_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .near_limit (near_limit),
        .angle_step (angle_step),
        .bounds     (bounds)
    );

    ssof_front #(
        .MAX_POINTS (MAX_POINTS),
        .RANGE_BITS (RANGE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_range   (s_axis_tdata[RANGE_BITS-1:0]),
        .in_last    (s_axis_tlast),
        .near_limit (near_limit),
        .angle_step (angle_step),
        .s2_ctrl    (s2_ctrl),
        .s2_angle   (s2_angle),
        .s2_ready   (s2_ready)
    );

    ssof_accum #(
        .MAX_POINTS (MAX_POINTS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s2_ctrl   (s2_ctrl),
        .s2_angle  (s2_angle),
        .s2_ready  (s2_ready),
        .bounds    (bounds),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

`ifndef SYNTH
    // A result word only appears after a last point left the multiply stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s2_ctrl.valid && s2_ctrl.last))
        else $error("result word without a last point");

    // Input back-pressure only comes from a stalled result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output free");

    // A last point that moves on must load the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_ctrl.valid && s2_ctrl.last && s2_ready) |=> m_axis_tvalid)
        else $error("last point dropped");
`endif

endmodule
